### src/bqs_pkg.sv
// ----------------------------------------------------------------------------
// bqs_pkg
// shared types and constants for the bracket and quote aware splitter
// ----------------------------------------------------------------------------
package bqs_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int PAIR_SLOTS_DEF  = 4;

    // packed registers carry four pairs, so a pair index is two bits
    localparam int PACKED_PAIRS = 4;
    localparam int PAIR_IDX_W   = 2;

    localparam logic [7:0] QUOTE_SINGLE = 8'h27;
    localparam logic [7:0] QUOTE_DOUBLE = 8'h22;

    // register indexes
    localparam logic [2:0] REG_MARKER_CHAR = 3'd0;
    localparam logic [2:0] REG_QUOTE_MODE  = 3'd1;
    localparam logic [2:0] REG_OPEN_CHARS  = 3'd2;
    localparam logic [2:0] REG_CLOSE_CHARS = 3'd3;
    localparam logic [2:0] REG_PAIR_COUNT  = 3'd4;

    // quote states
    localparam logic [1:0] QS_NONE   = 2'd0;
    localparam logic [1:0] QS_SINGLE = 2'd1;
    localparam logic [1:0] QS_DOUBLE = 2'd2;

    // part labels
    localparam logic [1:0] PART_HEAD   = 2'd0;
    localparam logic [1:0] PART_MARKER = 2'd1;
    localparam logic [1:0] PART_REST   = 2'd2;

    typedef struct packed {
        logic                  valid;
        logic                  push;
        logic                  pop;
        logic                  clear;
        logic [PAIR_IDX_W-1:0] data;
    } bqs_stack_req_t;

    typedef struct packed {
        logic                  empty;
        logic                  full;
        logic [PAIR_IDX_W-1:0] top;
    } bqs_stack_stat_t;

    typedef struct packed {
        logic       last_out;
        logic       stack_overflow;
        logic [1:0] part;
        logic [7:0] ch_out;
    } bqs_item_t;

endpackage

### src/bqs_stack.sv
// ----------------------------------------------------------------------------
// bqs_stack
// closer stack in a synchronous memory, top entry read ahead with push bypass
// ----------------------------------------------------------------------------
module bqs_stack #(
    parameter int STACK_DEPTH = bqs_pkg::STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bqs_pkg::bqs_stack_req_t  req,
    output bqs_pkg::bqs_stack_stat_t stat
);
    import bqs_pkg::*;

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [PAIR_IDX_W-1:0] mem [STACK_DEPTH];

    logic [LW-1:0]         level_reg;
    logic [LW-1:0]         level_next;
    logic [AW-1:0]         rd_addr;
    logic [PAIR_IDX_W-1:0] rd_data_reg;
    logic                  fwd_valid_reg;
    logic [PAIR_IDX_W-1:0] fwd_data_reg;

    always_comb
    begin
        level_next = level_reg;
        if (req.valid)
        begin
            if (req.clear)
                level_next = '0;
            else if (req.push)
                level_next = level_reg + 1'b1;
            else if (req.pop)
                level_next = level_reg - 1'b1;
        end
    end

    // read the entry that is on top after this cycle
    assign rd_addr = (level_next == '0) ? '0 : AW'(level_next - 1'b1);

    always_ff @(posedge clk)
    begin
        if (req.valid && req.push)
            mem[AW'(level_reg)] <= req.data;
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= req.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            fwd_valid_reg <= req.valid && req.push;
        end
    end

    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LW'(STACK_DEPTH));
    assign stat.top   = fwd_valid_reg ? fwd_data_reg : rd_data_reg;

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.pop && !req.clear |-> level_reg != '0)
        else $error("pop on empty stack");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.push && !req.clear |=>
            level_reg == LW'($past(level_reg) + 1'b1))
        else $error("push did not raise the level");

endmodule

### src/bqs_out_buf.sv
// ----------------------------------------------------------------------------
// bqs_out_buf
// output register with a skid stage that takes one input while the output stalls
// ----------------------------------------------------------------------------
module bqs_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bqs_pkg::bqs_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output bqs_pkg::bqs_item_t out_item
);
    import bqs_pkg::*;

    logic      out_valid_reg;
    logic      skid_valid_reg;
    bqs_item_t out_item_reg;
    bqs_item_t skid_item_reg;
    logic      out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            if (out_free)
                out_item_reg <= in_item;
            else
                skid_item_reg <= in_item;
        end
        else if (out_free)
            out_item_reg <= skid_item_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a transfer ahead of the output");

endmodule

### src/bracket_quote_aware_splitter.sv
// ----------------------------------------------------------------------------
// bracket_quote_aware_splitter
// labels each byte as head, marker or remainder, honoring quotes and brackets
// output: each byte is registered in the output buffer or its skid stage
// throughput: one byte per cycle unless stalled, set by the single stack top
//   read per byte from the registered memory port, with a bypass after a push
// reset: asynchronous, registers to defaults, empty stack, outside quotes;
//   stack memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module bracket_quote_aware_splitter #(
    parameter int STACK_DEPTH = bqs_pkg::STACK_DEPTH_DEF,
    parameter int PAIR_SLOTS  = bqs_pkg::PAIR_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // ch_out
    output logic [2:0]  m_tuser,   // part[1:0], stack_overflow
    output logic        m_tlast
);
    import bqs_pkg::*;

    localparam int PAIRS_MAX = (PAIR_SLOTS < PACKED_PAIRS) ? PAIR_SLOTS : PACKED_PAIRS;

    logic [7:0]  marker_char_reg;
    logic [1:0]  quote_mode_reg;
    logic [31:0] open_chars_reg;
    logic [31:0] close_chars_reg;
    logic [2:0]  pair_count_reg;

    logic [1:0]  quote_state_reg;
    logic [1:0]  quote_state_next;
    logic        split_done_reg;
    logic        split_done_next;

    bqs_stack_req_t  stk_req;
    bqs_stack_stat_t stk_stat;
    bqs_item_t       item;
    bqs_item_t       out_item;

    logic                  accept;
    logic [7:0]            c;
    logic [2:0]            pairs_used;
    logic [7:0]            close_byte;
    logic                  active;
    logic                  closer_hit;
    logic                  open_found;
    logic [PAIR_IDX_W-1:0] open_idx;
    logic                  open_hit;
    logic                  marker_hit;

    assign accept = s_tvalid && s_tready;
    assign c      = s_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_char_reg <= 8'd44;
            quote_mode_reg  <= 2'd3;
            open_chars_reg  <= '0;
            close_chars_reg <= '0;
            pair_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MARKER_CHAR: marker_char_reg <= cfg_data[7:0];
                REG_QUOTE_MODE:  quote_mode_reg  <= cfg_data[1:0];
                REG_OPEN_CHARS:  open_chars_reg  <= cfg_data;
                REG_CLOSE_CHARS: close_chars_reg <= cfg_data;
                REG_PAIR_COUNT:  pair_count_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign pairs_used = (pair_count_reg > 3'(PAIRS_MAX)) ? 3'(PAIRS_MAX) : pair_count_reg;
    assign close_byte = close_chars_reg[{stk_stat.top, 3'b000} +: 8];

    always_comb
    begin
        open_found = 1'b0;
        open_idx   = '0;
        for (int i = PACKED_PAIRS - 1; i >= 0; i--)
        begin
            if (3'(i) < pairs_used && open_chars_reg[i*8 +: 8] == c)
            begin
                open_found = 1'b1;
                open_idx   = PAIR_IDX_W'(i);
            end
        end
    end

    assign active     = !split_done_reg && quote_state_reg == QS_NONE;
    assign closer_hit = active && !stk_stat.empty && c == close_byte;
    assign open_hit   = active && !closer_hit && open_found;
    assign marker_hit = active && !closer_hit && !open_found
                        && c == marker_char_reg && stk_stat.empty;

    always_comb
    begin
        quote_state_next = quote_state_reg;
        if (!split_done_reg)
        begin
            if (quote_state_reg == QS_SINGLE && c == QUOTE_SINGLE)
                quote_state_next = QS_NONE;
            else if (quote_state_reg == QS_DOUBLE && c == QUOTE_DOUBLE)
                quote_state_next = QS_NONE;
            else if (active && !closer_hit && !open_found && !marker_hit)
            begin
                if (c == QUOTE_SINGLE && quote_mode_reg[0])
                    quote_state_next = QS_SINGLE;
                else if (c == QUOTE_DOUBLE && quote_mode_reg[1])
                    quote_state_next = QS_DOUBLE;
            end
        end
        if (s_tlast)
            quote_state_next = QS_NONE;
    end

    assign split_done_next = !s_tlast && (split_done_reg || marker_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_state_reg <= QS_NONE;
            split_done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            quote_state_reg <= quote_state_next;
            split_done_reg  <= split_done_next;
        end
    end

    assign stk_req.valid = accept;
    assign stk_req.push  = open_hit && !stk_stat.full;
    assign stk_req.pop   = closer_hit;
    assign stk_req.clear = s_tlast;
    assign stk_req.data  = open_idx;

    bqs_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (stk_req),
        .stat (stk_stat)
    );

    assign item.ch_out         = c;
    assign item.part           = split_done_reg ? PART_REST
                                 : (marker_hit ? PART_MARKER : PART_HEAD);
    assign item.stack_overflow = open_hit && stk_stat.full;
    assign item.last_out       = s_tlast;

    bqs_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (out_item)
    );

    assign m_tdata = out_item.ch_out;
    assign m_tuser = {out_item.stack_overflow, out_item.part};
    assign m_tlast = out_item.last_out;

    a_split_rest: assert property (@(posedge clk) disable iff (!rst_n)
        split_done_reg |-> !stk_req.push && !stk_req.pop && !marker_hit)
        else $error("state changed after the split");

    a_quote_no_stack: assert property (@(posedge clk) disable iff (!rst_n)
        quote_state_reg != QS_NONE |-> !stk_req.push && !stk_req.pop)
        else $error("stack touched inside quotes");

endmodule
